@@ rtl/fdp_pkg.sv @@
// ----------------------------------------------------------------------------
// fdp_pkg
// Shared types, constants and the binary64 round-and-pack function of the
// dot-product block.
// ----------------------------------------------------------------------------
package fdp_pkg;

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned OutDepth   = 2;

  localparam logic [63:0] CanonNan = 64'h7FF8_0000_0000_0000;
  localparam logic [10:0] ExpAllOnes = 11'h7FF;

  // Biased exponent with room for overflow and underflow ranges.
  typedef logic signed [12:0] exp_t;

  // One rounded product on its way to the accumulator.
  typedef struct packed {
    logic [63:0] value;
    logic        last;
  } prod_t;

  // Rounds a significand (hidden bit, 52 fraction bits, guard and sticky) to
  // nearest even and packs it. The exponent is at least one; a clear hidden
  // bit then means a subnormal or a zero.
  function automatic logic [63:0] round_pack(logic sgn, exp_t e, logic hid,
                                             logic [51:0] frac, logic g,
                                             logic st);
    logic [10:0] ef;
    logic        up;
    logic [62:0] mag;
    ef  = hid ? e[10:0] : 11'd0;
    up  = g & (st | frac[0]);
    mag = {ef, frac} + {62'd0, up};
    if (e >= 13'sd2047) begin
      mag = {ExpAllOnes, 52'd0};
    end
    return {sgn, mag};
  endfunction

endpackage

@@ rtl/fdp_mul.sv @@
// ----------------------------------------------------------------------------
// fdp_mul
// Front part: pipelined binary64 multiplier with round to nearest even.
// ----------------------------------------------------------------------------
module fdp_mul
  import fdp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic [63:0] x_i,
  input  logic [63:0] y_i,
  input  logic        last_i,
  output logic        ready_o,
  output logic        out_valid_o,
  output prod_t       out_o,
  input  logic        out_full_i
);

  logic adv;

  // Stage 1: unpacked operands and partial products.
  logic        v1_q, s1_sgn_q, s1_nan_q, s1_inf_q, s1_last_q;
  exp_t        s1_e_q;
  logic [53:0] s1_ll_q;
  logic [52:0] s1_lh_q, s1_hl_q;
  logic [51:0] s1_hh_q;
  // Stage 2: full product.
  logic         v2_q, s2_sgn_q, s2_nan_q, s2_inf_q, s2_last_q;
  exp_t         s2_e_q;
  logic [105:0] s2_p_q;
  // Stage 3 and 4: normalisation.
  logic         v3_q, s3_sgn_q, s3_nan_q, s3_inf_q, s3_last_q;
  exp_t         s3_e_q;
  logic [105:0] s3_p_q;
  logic         v4_q, s4_sgn_q, s4_nan_q, s4_inf_q, s4_last_q;
  exp_t         s4_e_q;
  logic [105:0] s4_p_q;
  // Stage 5: denormalisation.
  logic         v5_q, s5_sgn_q, s5_nan_q, s5_inf_q, s5_last_q, s5_st_q;
  exp_t         s5_e_q;
  logic [105:0] s5_p_q;
  // Stage 6: packed product.
  logic         v6_q;
  prod_t        s6_q;

  assign adv         = ~v6_q | ~out_full_i;
  assign ready_o     = adv;
  assign out_valid_o = v6_q;
  assign out_o       = s6_q;

  logic [10:0] ex, ey, exn, eyn;
  logic [52:0] ma, mb;
  logic        nan_x, nan_y, inf_x, inf_y, zero_x, zero_y;

  always_comb begin
    ex     = x_i[62:52];
    ey     = y_i[62:52];
    exn    = (ex == 11'd0) ? 11'd1 : ex;
    eyn    = (ey == 11'd0) ? 11'd1 : ey;
    ma     = {ex != 11'd0, x_i[51:0]};
    mb     = {ey != 11'd0, y_i[51:0]};
    nan_x  = (ex == ExpAllOnes) && (x_i[51:0] != 52'd0);
    nan_y  = (ey == ExpAllOnes) && (y_i[51:0] != 52'd0);
    inf_x  = (ex == ExpAllOnes) && (x_i[51:0] == 52'd0);
    inf_y  = (ey == ExpAllOnes) && (y_i[51:0] == 52'd0);
    zero_x = x_i[62:0] == 63'd0;
    zero_y = y_i[62:0] == 63'd0;
  end

  logic [105:0] p3, p4, p5;
  exp_t         e3, e4, e5;
  logic         st5;

  always_comb begin
    p3 = s2_p_q;
    e3 = s2_e_q;
    if (p3[105 -: 64] == 64'd0 && e3 > 13'sd64) begin
      p3 = p3 << 64;
      e3 = e3 - 13'sd64;
    end
    if (p3[105 -: 32] == 32'd0 && e3 > 13'sd32) begin
      p3 = p3 << 32;
      e3 = e3 - 13'sd32;
    end
    if (p3[105 -: 16] == 16'd0 && e3 > 13'sd16) begin
      p3 = p3 << 16;
      e3 = e3 - 13'sd16;
    end
  end

  always_comb begin
    p4 = s3_p_q;
    e4 = s3_e_q;
    if (p4[105 -: 8] == 8'd0 && e4 > 13'sd8) begin
      p4 = p4 << 8;
      e4 = e4 - 13'sd8;
    end
    if (p4[105 -: 4] == 4'd0 && e4 > 13'sd4) begin
      p4 = p4 << 4;
      e4 = e4 - 13'sd4;
    end
    if (p4[105 -: 2] == 2'd0 && e4 > 13'sd2) begin
      p4 = p4 << 2;
      e4 = e4 - 13'sd2;
    end
    if (!p4[105] && e4 > 13'sd1) begin
      p4 = p4 << 1;
      e4 = e4 - 13'sd1;
    end
  end

  logic [12:0] rs_full;
  logic [6:0]  rs;

  always_comb begin
    p5      = s4_p_q;
    e5      = s4_e_q;
    st5     = 1'b0;
    rs_full = 13'd1 - s4_e_q;
    rs      = (rs_full > 13'd127) ? 7'd127 : rs_full[6:0];
    if (s4_e_q < 13'sd1) begin
      p5  = s4_p_q >> rs;
      st5 = |(s4_p_q & ~({106{1'b1}} << rs));
      e5  = 13'sd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else if (adv) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
      v6_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_sgn_q  <= x_i[63] ^ y_i[63];
      s1_nan_q  <= nan_x | nan_y | (inf_x & zero_y) | (zero_x & inf_y);
      s1_inf_q  <= inf_x | inf_y;
      s1_last_q <= last_i;
      s1_e_q    <= $signed({2'b00, exn}) + $signed({2'b00, eyn}) - 13'sd1022;
      s1_ll_q   <= ma[26:0] * mb[26:0];
      s1_lh_q   <= ma[26:0] * mb[52:27];
      s1_hl_q   <= ma[52:27] * mb[26:0];
      s1_hh_q   <= ma[52:27] * mb[52:27];

      s2_sgn_q  <= s1_sgn_q;
      s2_nan_q  <= s1_nan_q;
      s2_inf_q  <= s1_inf_q;
      s2_last_q <= s1_last_q;
      s2_e_q    <= s1_e_q;
      s2_p_q    <= {s1_hh_q, 54'd0} + {26'd0, s1_lh_q, 27'd0}
                 + {26'd0, s1_hl_q, 27'd0} + {52'd0, s1_ll_q};

      s3_sgn_q  <= s2_sgn_q;
      s3_nan_q  <= s2_nan_q;
      s3_inf_q  <= s2_inf_q;
      s3_last_q <= s2_last_q;
      s3_e_q    <= e3;
      s3_p_q    <= p3;

      s4_sgn_q  <= s3_sgn_q;
      s4_nan_q  <= s3_nan_q;
      s4_inf_q  <= s3_inf_q;
      s4_last_q <= s3_last_q;
      s4_e_q    <= e4;
      s4_p_q    <= p4;

      s5_sgn_q  <= s4_sgn_q;
      s5_nan_q  <= s4_nan_q;
      s5_inf_q  <= s4_inf_q;
      s5_last_q <= s4_last_q;
      s5_e_q    <= e5;
      s5_p_q    <= p5;
      s5_st_q   <= st5;

      s6_q.last <= s5_last_q;
      if (s5_nan_q) begin
        s6_q.value <= CanonNan;
      end else if (s5_inf_q) begin
        s6_q.value <= {s5_sgn_q, ExpAllOnes, 52'd0};
      end else begin
        s6_q.value <= round_pack(s5_sgn_q, s5_e_q, s5_p_q[105], s5_p_q[104:53],
                                 s5_p_q[52], (|s5_p_q[51:0]) | s5_st_q);
      end
    end
  end

endmodule

@@ rtl/fdp_queue.sv @@
// ----------------------------------------------------------------------------
// fdp_queue
// Short queue of rounded products between the multiplier and the adder.
// ----------------------------------------------------------------------------
module fdp_queue
  import fdp_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  prod_t data_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  empty_o,
  output prod_t data_o
);

  localparam int unsigned PtrW = $clog2(QueueDepth);

  prod_t           mem_q [QueueDepth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [PtrW:0]   cnt_q;
  logic            do_push, do_pop;

  assign full_o  = cnt_q == (PtrW+1)'(QueueDepth);
  assign empty_o = cnt_q == '0;
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

@@ rtl/fdp_acc.sv @@
// ----------------------------------------------------------------------------
// fdp_acc
// Back part: four-step binary64 adder into the running sum, and the result
// queue.
// ----------------------------------------------------------------------------
module fdp_acc
  import fdp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        q_empty_i,
  input  prod_t       q_data_i,
  output logic        q_pop_o,
  output logic        empty_o,
  input  logic        pop_i,
  output logic [63:0] dot_value_o
);

  localparam int unsigned OutPtrW = $clog2(OutDepth);

  logic [63:0] acc_q;
  logic        busy_q;
  logic [1:0]  phase_q;

  // Step registers.
  logic        sgn_q, sub_q, nan_q, inf_q, inf_sgn_q, last_q, zero_q;
  logic [52:0] mbig_q, msml_q;
  logic [10:0] d_q;
  exp_t        e_q;
  logic [56:0] sum_q;
  logic [55:0] m_q;

  // Result queue.
  logic [63:0]        out_mem_q [OutDepth];
  logic [OutPtrW-1:0] out_wr_q, out_rd_q;
  logic [OutPtrW:0]   out_cnt_q;
  logic               out_push, out_pop;

  logic start;
  assign start   = ~busy_q & ~q_empty_i & (out_cnt_q != (OutPtrW+1)'(OutDepth));
  assign q_pop_o = start;

  // Alignment: order the operands by magnitude.
  logic [63:0] a, b;
  logic [10:0] ea, eb, ean, ebn;
  logic        nan_a, nan_b, inf_a, inf_b, swap;

  always_comb begin
    a     = acc_q;
    b     = q_data_i.value;
    ea    = a[62:52];
    eb    = b[62:52];
    ean   = (ea == 11'd0) ? 11'd1 : ea;
    ebn   = (eb == 11'd0) ? 11'd1 : eb;
    nan_a = (ea == ExpAllOnes) && (a[51:0] != 52'd0);
    nan_b = (eb == ExpAllOnes) && (b[51:0] != 52'd0);
    inf_a = (ea == ExpAllOnes) && (a[51:0] == 52'd0);
    inf_b = (eb == ExpAllOnes) && (b[51:0] == 52'd0);
    swap  = b[62:0] > a[62:0];
  end

  // Shift the smaller operand and add.
  logic [5:0]  sh;
  logic [55:0] sm, al;
  always_comb begin
    sh = (d_q > 11'd63) ? 6'd63 : d_q[5:0];
    sm = {msml_q, 3'b000};
    al = (sm >> sh) | {55'd0, |(sm & ~({56{1'b1}} << sh))};
  end

  // Normalise the sum.
  logic [55:0] mn;
  exp_t        en;
  always_comb begin
    if (sum_q[56]) begin
      mn = {sum_q[56:2], sum_q[1] | sum_q[0]};
      en = e_q + 13'sd1;
    end else begin
      mn = sum_q[55:0];
      en = e_q;
      if (mn[55 -: 32] == 32'd0 && en > 13'sd32) begin
        mn = mn << 32;
        en = en - 13'sd32;
      end
      if (mn[55 -: 16] == 16'd0 && en > 13'sd16) begin
        mn = mn << 16;
        en = en - 13'sd16;
      end
      if (mn[55 -: 8] == 8'd0 && en > 13'sd8) begin
        mn = mn << 8;
        en = en - 13'sd8;
      end
      if (mn[55 -: 4] == 4'd0 && en > 13'sd4) begin
        mn = mn << 4;
        en = en - 13'sd4;
      end
      if (mn[55 -: 2] == 2'd0 && en > 13'sd2) begin
        mn = mn << 2;
        en = en - 13'sd2;
      end
      if (!mn[55] && en > 13'sd1) begin
        mn = mn << 1;
        en = en - 13'sd1;
      end
    end
  end

  // Round and pack; an exact cancellation gives positive zero.
  logic [63:0] res;
  logic        rsgn;
  always_comb begin
    rsgn = zero_q ? (sgn_q & ~sub_q) : sgn_q;
    if (nan_q) begin
      res = CanonNan;
    end else if (inf_q) begin
      res = {inf_sgn_q, ExpAllOnes, 52'd0};
    end else begin
      res = round_pack(rsgn, e_q, m_q[55], m_q[54:3], m_q[2], |m_q[1:0]);
    end
  end

  assign out_push = busy_q && (phase_q == 2'd3) && last_q;
  assign out_pop  = pop_i & ~empty_o;
  assign empty_o  = out_cnt_q == '0;
  assign dot_value_o = out_mem_q[out_rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      phase_q   <= 2'd0;
      acc_q     <= 64'd0;
      out_wr_q  <= '0;
      out_rd_q  <= '0;
      out_cnt_q <= '0;
    end else begin
      if (start) begin
        busy_q  <= 1'b1;
        phase_q <= 2'd1;
      end else if (busy_q) begin
        phase_q <= phase_q + 2'd1;
        if (phase_q == 2'd3) begin
          busy_q <= 1'b0;
          acc_q  <= last_q ? 64'd0 : res;
        end
      end
      if (out_push) begin
        out_wr_q <= out_wr_q + 1'b1;
      end
      if (out_pop) begin
        out_rd_q <= out_rd_q + 1'b1;
      end
      if (out_push && !out_pop) begin
        out_cnt_q <= out_cnt_q + 1'b1;
      end else if (out_pop && !out_push) begin
        out_cnt_q <= out_cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      sgn_q     <= swap ? b[63] : a[63];
      sub_q     <= a[63] ^ b[63];
      nan_q     <= nan_a | nan_b | (inf_a & inf_b & (a[63] != b[63]));
      inf_q     <= inf_a | inf_b;
      inf_sgn_q <= inf_a ? a[63] : b[63];
      last_q    <= q_data_i.last;
      mbig_q    <= swap ? {eb != 11'd0, b[51:0]} : {ea != 11'd0, a[51:0]};
      msml_q    <= swap ? {ea != 11'd0, a[51:0]} : {eb != 11'd0, b[51:0]};
      d_q       <= swap ? (ebn - ean) : (ean - ebn);
      e_q       <= $signed({2'b00, swap ? ebn : ean});
    end else if (busy_q && phase_q == 2'd1) begin
      sum_q  <= sub_q ? ({1'b0, mbig_q, 3'b000} - {1'b0, al})
                      : ({1'b0, mbig_q, 3'b000} + {1'b0, al});
    end else if (busy_q && phase_q == 2'd2) begin
      m_q    <= mn;
      e_q    <= en;
      zero_q <= sum_q == 57'd0;
    end
    if (out_push) begin
      out_mem_q[out_wr_q] <= res;
    end
  end

endmodule

@@ rtl/fp64_dot_product.sv @@
// ----------------------------------------------------------------------------
// fp64_dot_product
// Sequential binary64 dot product with separately rounded multiply and add.
// ----------------------------------------------------------------------------
// Each item carries a pair of binary64 elements. The pair is multiplied with
// round to nearest even in a six-stage multiplier that takes an item every
// cycle unless its output stalls; the rounded products wait in a four-entry
// queue and are added in arrival order to a running binary64 sum by an adder
// that works in four steps (align, add, normalise, round) and takes no new
// product until it is through with the last one. Short bursts are accepted at
// one per cycle until the queue and the multiplier pipeline are
// full. On an item marked last, the finished sum is placed in a two-entry
// result queue and the accumulator returns to positive zero. A NaN result is
// always delivered as the canonical quiet NaN. Subnormals are handled exactly
// and overflow gives a correctly signed infinity.
module fp64_dot_product
  import fdp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [63:0] x_element_i,
  input  logic [63:0] y_element_i,
  input  logic        last_pair_i,
  output logic        empty,
  input  logic        pop,
  output logic [63:0] dot_value_o
);

  logic  mul_ready, mul_valid, q_full, q_empty, q_pop;
  prod_t mul_prod, q_head;

  // The multiplier pipeline stalls as a whole while its last stage cannot
  // hand its product to the queue.
  assign full = ~mul_ready;

  fdp_mul u_mul (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (push & mul_ready),
    .x_i         (x_element_i),
    .y_i         (y_element_i),
    .last_i      (last_pair_i),
    .ready_o     (mul_ready),
    .out_valid_o (mul_valid),
    .out_o       (mul_prod),
    .out_full_i  (q_full)
  );

  fdp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (mul_valid),
    .data_i  (mul_prod),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .data_o  (q_head)
  );

  fdp_acc u_acc (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_data_i    (q_head),
    .q_pop_o     (q_pop),
    .empty_o     (empty),
    .pop_i       (pop),
    .dot_value_o (dot_value_o)
  );

endmodule

@@ tb/sv/fp64_dot_product_tb.sv @@
// ----------------------------------------------------------------------------
// fp64_dot_product_tb
// Self-checking testbench for the sequential binary64 dot-product block.
// ----------------------------------------------------------------------------
// Element pairs are pushed in bursts with random gaps. A scoreboard computes
// the expected dot product with the simulator's own binary64 arithmetic,
// rounding the product and the sum separately, and compares it with each
// popped result. The receiver stalls on its own pattern and once holds off
// for a long stretch, so that the block fills up and refuses new items.
// ----------------------------------------------------------------------------
module fp64_dot_product_tb
  import fdp_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RandomItems = 1425;
  localparam int unsigned IdleLimit   = 5000;
  localparam int unsigned LongHold    = 400;

  // Expected dot products, built in arrival order.
  class dot_scoreboard;
    real             acc_sum;
    logic [63:0]     sums_due[$];
    int unsigned     mismatches;

    function new();
      acc_sum    = 0.0;
      mismatches = 0;
    endfunction

    // One accepted pair: the product is rounded on its own, then added.
    function void note_pair(logic [63:0] x, logic [63:0] y, logic last);
      real         prod;
      logic [63:0] bits;
      prod    = $bitstoreal(x) * $bitstoreal(y);
      acc_sum = acc_sum + prod;
      if (last) begin
        bits = $realtobits(acc_sum);
        // Any NaN comes out in its canonical quiet form.
        if (bits[62:52] == ExpAllOnes && bits[51:0] != 52'd0) begin
          bits = CanonNan;
        end
        sums_due.push_back(bits);
        acc_sum = 0.0;
      end
    endfunction

    function void check_sum(logic [63:0] got);
      logic [63:0] want;
      if (sums_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("ERROR: unexpected result %h", got);
        end
        return;
      end
      want = sums_due.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("ERROR: dot_value expected %h actual %h", want, got);
        end
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        push;
  logic        full;
  logic [63:0] x_element_i;
  logic [63:0] y_element_i;
  logic        last_pair_i;
  logic        empty;
  logic        pop;
  logic [63:0] dot_value_o;

  dot_scoreboard sb;
  int unsigned   idle_cycles = 0;
  bit            hold_done;

  fp64_dot_product u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .x_element_i (x_element_i),
    .y_element_i (y_element_i),
    .last_pair_i (last_pair_i),
    .empty       (empty),
    .pop         (pop),
    .dot_value_o (dot_value_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // A random element. Most are moderate normals so that sums stay finite and
  // rounding is exercised; the rest cover zeros, subnormals, infinities,
  // NaNs, values near the top and bottom of the range and raw bit patterns.
  function automatic logic [63:0] rand_element();
    logic        sgn;
    logic [51:0] frac;
    sgn  = 1'($urandom_range(0, 1));
    frac = 52'({$urandom, $urandom});
    case ($urandom_range(0, 19))
      0:       return {sgn, 63'd0};
      1:       return {sgn, 11'd0, frac};
      2:       return {sgn, ExpAllOnes, 52'd0};
      3:       return {sgn, ExpAllOnes, frac | 52'd1};
      4:       return {sgn, 11'(2046 - $urandom_range(0, 3)), frac};
      5:       return {sgn, 11'($urandom_range(1, 30)), frac};
      6, 7:    return {$urandom, $urandom};
      default: return {sgn, 11'(1023 - 40 + $urandom_range(0, 80)), frac};
    endcase
  endfunction

  // Offers one item and holds it until the block takes it.
  task automatic send_pair(logic [63:0] x, logic [63:0] y, logic last);
    push        <= 1'b1;
    x_element_i <= x;
    y_element_i <= y;
    last_pair_i <= last;
    do @(posedge clk_i); while (full);
    sb.note_pair(x, y, last);
  endtask

  // Drops push for a random gap between bursts, or keeps it up.
  task automatic maybe_gap(ref int burst_left);
    int unsigned gap;
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    burst_left = $urandom_range(0, 12);
    gap        = $urandom_range(0, 6);
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Receiver: a stall pattern of its own, with one long hold-off while the
  // sender keeps pushing.
  initial begin
    int unsigned hold_left;
    int unsigned hold_at;
    int unsigned stall_pct;
    int unsigned cyc;
    pop       = 1'b0;
    hold_done = 1'b0;
    hold_left = 0;
    cyc       = 0;
    stall_pct = 0;
    hold_at   = $urandom_range(800, 2000);
    @(posedge rst_ni);
    forever begin
      cyc++;
      if (cyc % 256 == 0) begin
        stall_pct = $urandom_range(0, 3) * 25;
      end
      if (cyc == hold_at) begin
        hold_left = LongHold;
      end
      if (hold_left != 0) begin
        hold_left--;
        if (hold_left == 0) hold_done = 1'b1;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(1, 100) > stall_pct);
      end
      @(posedge clk_i);
      if (pop && !empty) begin
        sb.check_sum(dot_value_o);
      end
    end
  end

  // Watchdog: counts cycles in which neither side moves an item.
  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IdleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    int          burst_left;
    int unsigned len;
    int unsigned sent;
    logic [63:0] pinf;
    logic [63:0] qnan;
    logic [63:0] maxn;
    logic [63:0] tiny;
    sb          = new();
    burst_left  = 0;
    rst_ni      <= 1'b0;
    push        <= 1'b0;
    x_element_i <= '0;
    y_element_i <= '0;
    last_pair_i <= 1'b0;
    pinf = {1'b0, ExpAllOnes, 52'd0};
    qnan = {1'b1, ExpAllOnes, 52'hA_BCDE_F012_3456};
    maxn = 64'h7FEF_FFFF_FFFF_FFFF;
    tiny = 64'h0000_0000_0000_0001;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part.
    // Single pair of plain values.
    send_pair(64'h3FF8_0000_0000_0000, 64'hC000_0000_0000_0000, 1'b1);
    // Negative-zero products still sum to positive zero.
    send_pair(64'h8000_0000_0000_0000, 64'h3FF0_0000_0000_0000, 1'b0);
    send_pair(64'h0000_0000_0000_0000, 64'hBFF0_0000_0000_0000, 1'b1);
    // Infinity times zero gives NaN.
    send_pair(pinf, 64'h0, 1'b1);
    // Infinity minus infinity gives NaN.
    send_pair(pinf, 64'h3FF0_0000_0000_0000, 1'b0);
    send_pair(pinf, 64'hBFF0_0000_0000_0000, 1'b1);
    // A NaN in the accumulator survives later finite pairs.
    send_pair(qnan, 64'h4000_0000_0000_0000, 1'b0);
    send_pair(64'h3FF0_0000_0000_0000, 64'h3FF0_0000_0000_0000, 1'b1);
    // Overflow to both infinities.
    send_pair(maxn, maxn, 1'b1);
    send_pair(maxn, {1'b1, maxn[62:0]}, 1'b1);
    send_pair(maxn, 64'h3FF0_0000_0000_0000, 1'b0);
    send_pair(maxn, 64'h3FF0_0000_0000_0000, 1'b1);
    // Gradual underflow and subnormal sums.
    send_pair(tiny, 64'h3FF0_0000_0000_0000, 1'b0);
    send_pair(64'h000F_FFFF_FFFF_FFFF, 64'h3FF0_0000_0000_0000, 1'b1);
    send_pair(64'h0010_0000_0000_0000, 64'h3FE0_0000_0000_0000, 1'b1);
    send_pair(64'h3000_0000_0000_0001, 64'h3000_0000_0000_0001, 1'b1);
    // Cancellation down to zero and a sum that rounds up.
    send_pair(64'h4000_0000_0000_0001, 64'h3FF0_0000_0000_0000, 1'b0);
    send_pair(64'hC000_0000_0000_0001, 64'h3FF0_0000_0000_0000, 1'b1);
    send_pair(64'h4340_0000_0000_0000, 64'h3FF0_0000_0000_0000, 1'b0);
    send_pair(64'h3FF0_0000_0000_0000, 64'h3FF8_0000_0000_0000, 1'b1);
    // All-ones and all-zeros patterns.
    send_pair('1, '1, 1'b1);
    send_pair('0, '0, 1'b1);

    // Random vectors with random lengths, mostly short.
    sent = 0;
    while (sent < RandomItems) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                        : $urandom_range(1, 6);
      for (int unsigned i = 0; i < len; i++) begin
        maybe_gap(burst_left);
        send_pair(rand_element(), rand_element(),
                  (i == len - 1) || (sent + 1 >= RandomItems));
        sent++;
        if (sent >= RandomItems) break;
      end
    end
    push <= 1'b0;

    // Drain: the long hold-off must have happened and every sum arrived.
    while (!hold_done || sb.sums_due.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
    if (sb.mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/fdp_pkg.sv
rtl/fdp_mul.sv
rtl/fdp_queue.sv
rtl/fdp_acc.sv
rtl/fp64_dot_product.sv
tb/sv/fp64_dot_product_tb.sv
